// File: rtl/ir_image_validator_defines.svh
// Assertion macros for the ir_image_validator RTL, used by irv_accum
`ifndef IR_IMAGE_VALIDATOR_DEFINES_SVH
`define IR_IMAGE_VALIDATOR_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define IRV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a property in the next cycle.
`define IRV_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/irv_pkg.sv
// Shared types, constants and the FNV-1a step for the image validator
package irv_pkg;

	localparam int HEADER_BYTES = 32;
	localparam int RECORD_BYTES = 32;
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
	localparam int COUNT_W      = 64;
	localparam int CFG_IDX_W    = 8;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	// "TJIR" read as a little-endian word
	localparam logic [31:0] MAGIC     = 32'h5249_4A54;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_MAGIC     = 3'd1;
	localparam logic [2:0] STATUS_VERSION   = 3'd2;
	localparam logic [2:0] STATUS_LAYOUT    = 3'd3;
	localparam logic [2:0] STATUS_TRUNCATED = 3'd4;
	localparam logic [2:0] STATUS_CHECKSUM  = 3'd5;
	localparam logic [2:0] STATUS_REGLIMIT  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REGISTERS  = CFG_IDX_W'(1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} image_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] num_insns;
		logic [15:0] num_regs;
		logic [15:0] num_args;
		logic [15:0] num_locals;
		logic [31:0] body_checksum;
	} verdict_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [15:0]          data;
	} cfg_write_t;

	typedef struct packed {
		logic [15:0] format_version;
		logic [15:0] max_registers;
	} cfg_regs_t;

	typedef logic [HEADER_BYTES-1:0][7:0] header_t;

	// Image state frozen at the last byte
	typedef struct packed {
		header_t            hdr;
		logic [31:0]        hash;
		logic [COUNT_W-1:0] size;
	} snap_t;

	// Handshake between the accumulator and the checker
	typedef struct packed {
		logic valid;
		snap_t data;
	} snap_req_t;

	// FNV-1a: xor the byte in, then multiply by 2^24 + 0x193 as shifts and adds
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// File: rtl/irv_stream_if.sv
// Valid/ready channel carrying one request payload
interface irv_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/irv_accum.sv
// Input register, byte counter, header capture and body hash
`include "ir_image_validator_defines.svh"

module irv_accum import irv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  image_item_t in_item,
	output snap_req_t   snap,
	input  logic        out_free
);

	logic               valid_s1;
	image_item_t        item_s1;
	logic [COUNT_W-1:0] counter_q;
	header_t            header_q;
	logic [31:0]        hash_q;
	logic               snap_valid_q;
	snap_t              snap_s2;

	logic               snap_free;
	logic               s1_fire;
	logic               in_header;
	header_t            hdr_next;
	logic [31:0]        hash_next;
	logic [COUNT_W-1:0] count_next;

	assign snap_free = !snap_valid_q || out_free;
	// A last byte waits in stage 1 while the snapshot slot is occupied and not being freed
	assign s1_fire   = valid_s1 && (!item_s1.last || snap_free);
	assign in_ready  = !valid_s1 || s1_fire;

	assign in_header = counter_q < COUNT_W'(HEADER_BYTES);

	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_next[i] = (in_header && counter_q[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) ?
				item_s1.data_byte : header_q[i];
		end
		hash_next  = in_header ? hash_q : fnv_step(hash_q, item_s1.data_byte);
		count_next = (&counter_q) ? counter_q : counter_q + COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			header_q  <= '0;
			hash_q    <= FNV_BASIS;
		end else if (s1_fire) begin
			if (item_s1.last) begin
				counter_q <= '0;
				header_q  <= '0;
				hash_q    <= FNV_BASIS;
			end else begin
				counter_q <= count_next;
				header_q  <= hdr_next;
				hash_q    <= hash_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.last) begin
			snap_valid_q <= 1'b1;
		end else if (out_free) begin
			snap_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last) begin
			snap_s2.hdr  <= hdr_next;
			snap_s2.hash <= hash_next;
			snap_s2.size <= count_next;
		end
	end

	assign snap.valid = snap_valid_q;
	assign snap.data  = snap_s2;

	`IRV_ASSERT(a_hash_idle_in_header, in_header |-> (hash_q == FNV_BASIS), "hash moved in header")
	`IRV_ASSERT_NEXT(a_clear_after_last, s1_fire && item_s1.last, (counter_q == '0) && (hash_q == FNV_BASIS), "state not cleared after last byte")
	`IRV_ASSERT_NEXT(a_snap_held, snap_valid_q && !out_free, snap_valid_q && $stable(snap_s2.size), "snapshot lost while stalled")
	`IRV_ASSERT(a_snap_nonempty, snap_valid_q |-> (snap_s2.size != '0), "empty image snapshot")

endmodule

// File: rtl/irv_judge.sv
// Verdict logic and result register
module irv_judge import irv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  snap_req_t     snap,
	output logic          out_free,
	input  cfg_regs_t     cfg_regs,
	output logic          out_valid,
	input  logic          out_ready,
	output verdict_item_t out_item
);

	logic               out_valid_q;
	verdict_item_t      out_q;
	verdict_item_t      res;
	logic               short_img;
	logic [COUNT_W-1:0] expected;
	header_t            h;

	assign out_free = !out_valid_q || out_ready;
	assign h        = snap.data.hdr;

	always_comb begin
		short_img = snap.data.size < COUNT_W'(HEADER_BYTES);
		expected  = COUNT_W'(h[11:8]) * COUNT_W'(RECORD_BYTES) + COUNT_W'(HEADER_BYTES);

		if (short_img || h[3:0] != MAGIC) begin
			res.status = STATUS_MAGIC;
		end else if (h[5:4] != cfg_regs.format_version) begin
			res.status = STATUS_VERSION;
		end else if (h[7:6] != 16'(HEADER_BYTES) || h[19:18] != 16'(RECORD_BYTES) ||
			h[31:24] != snap.data.size) begin
			res.status = STATUS_LAYOUT;
		end else if (expected != snap.data.size) begin
			res.status = STATUS_TRUNCATED;
		end else if (h[23:20] != snap.data.hash) begin
			res.status = STATUS_CHECKSUM;
		end else if (h[13:12] > cfg_regs.max_registers || h[17:16] > cfg_regs.max_registers) begin
			res.status = STATUS_REGLIMIT;
		end else begin
			res.status = STATUS_OK;
		end

		// a short image reports no header counts
		res.num_insns     = short_img ? 32'd0 : h[11:8];
		res.num_regs      = short_img ? 16'd0 : h[13:12];
		res.num_args      = short_img ? 16'd0 : h[15:14];
		res.num_locals    = short_img ? 16'd0 : h[17:16];
		res.body_checksum = snap.data.hash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && snap.valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/ir_image_validator.sv
// After its last byte is taken, a result passes the snapshot and then the result register.
// Throughput: one image byte per cycle; a last byte waits while the snapshot slot is full.
// A finished verdict waits in the result register while the next image keeps streaming.
// Reset (arst_n low) clears the byte count, header bytes, hash and all valid flags at once,
// and loads format_version = 1, max_registers = 256; no clearing pass is needed.
module ir_image_validator import irv_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	irv_stream_if.sink   image,
	irv_stream_if.source verdict,
	irv_stream_if.sink   cfg
);

	cfg_regs_t     cfg_q;
	snap_req_t     snap;
	logic          out_free;
	image_item_t   in_item;
	cfg_write_t    cfg_req;
	verdict_item_t out_item;

	assign in_item = image.payload;
	assign cfg_req = cfg.payload;

	// Configuration writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format_version <= 16'd1;
			cfg_q.max_registers  <= 16'd256;
		end else if (cfg.valid) begin
			case (cfg_req.index)
				CFG_FORMAT_VERSION: cfg_q.format_version <= cfg_req.data;
				CFG_MAX_REGISTERS:  cfg_q.max_registers  <= cfg_req.data;
				default: ;
			endcase
		end
	end

	// Register each byte, advance the count, capture the header, hash the body
	irv_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (image.valid),
		.in_ready (image.ready),
		.in_item  (in_item),
		.snap     (snap),
		.out_free (out_free)
	);

	// Turn the frozen image state into one verdict request and hold it until taken
	irv_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap),
		.out_free  (out_free),
		.cfg_regs  (cfg_q),
		.out_valid (verdict.valid),
		.out_ready (verdict.ready),
		.out_item  (out_item)
	);

	assign verdict.payload = out_item;

endmodule
